// File: src/lswc_pkg.sv
// Shared types and constants for the line segment window clipper.
// Used by the controller, the datapath, the top level and the testbench.
package lswc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int CLIP_LIMIT      = 4;

    // outcode bits
    localparam logic [3:0] OC_LEFT  = 4'b0001;
    localparam logic [3:0] OC_RIGHT = 4'b0010;
    localparam logic [3:0] OC_BELOW = 4'b0100;
    localparam logic [3:0] OC_ABOVE = 4'b1000;

    // register indexes
    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_step;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic trivial_acc;
        logic trivial_rej;
        logic zero_span;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// File: src/line_segment_window_clip_core.sv
// Line segment clipper against a configurable window (Cohen-Sutherland).
// Usage: write the four window edges over the APB port (byte address
// 4*i: x_min, x_max, y_min, y_max; 24-bit signed, 8 fraction bits),
// then stream segments in on s_tdata and take results from m_tdata/m_tuser.
// One segment is processed at a time, and no new one is taken before the
// last is finished. A trivially decided segment passes from evaluation
// straight to the output step; each endpoint move adds setup, a multiply,
// the one-bit-per-cycle restoring divider that follows the multiplier and
// the update, after which the segment is evaluated again. At most four
// moves; a move across a zero span skips the multiply and the divide.
// The result sits in an output register; the next segment is accepted
// while it waits, and a stalled m_tready holds it. A finished segment
// waits for the output register to free up before its result is written.
// Reset (aresetn, synchronous, active low) returns the window to
// +-320.0 by +-240.0 and drops any pending item and result.
// Depends on lswc_pkg, lswc_ctrl, lswc_datapath.
module line_segment_window_clip_core #(
    parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = lswc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [3:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // accepted
    output logic                                   m_tuser
);
    import lswc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = ((4 * W + 7) / 8) * 8;
    localparam logic signed [W-1:0] RST_X = W'(64'sd320 <<< FRAC_BITS);
    localparam logic signed [W-1:0] RST_Y = W'(64'sd240 <<< FRAC_BITS);

    logic signed [W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic                wr;
    cmd_t                cmd;
    status_t             st;
    logic [W-1:0]        osx, osy, oex, oey;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= -RST_X;
            x_max_reg <= RST_X;
            y_min_reg <= -RST_Y;
            y_max_reg <= RST_Y;
        end else if (wr) begin
            case (paddr[3:2])
                REG_X_MIN: x_min_reg <= W'(pwdata);
                REG_X_MAX: x_max_reg <= W'(pwdata);
                REG_Y_MIN: y_min_reg <= W'(pwdata);
                REG_Y_MAX: y_max_reg <= W'(pwdata);
                default:   x_min_reg <= x_min_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_X_MIN: prdata = 32'(x_min_reg);
            REG_X_MAX: prdata = 32'(x_max_reg);
            REG_Y_MIN: prdata = 32'(y_min_reg);
            REG_Y_MAX: prdata = 32'(y_max_reg);
            default:   prdata = '0;
        endcase
    end

    lswc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lswc_datapath #(
        .COORD_WIDTH (W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .win_x_min (x_min_reg),
        .win_x_max (x_max_reg),
        .win_y_min (y_min_reg),
        .win_y_max (y_max_reg),
        .in_sx     (s_tdata[W-1:0]),
        .in_sy     (s_tdata[2*W-1:W]),
        .in_ex     (s_tdata[3*W-1:2*W]),
        .in_ey     (s_tdata[4*W-1:3*W]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_acc   (m_tuser),
        .out_sx    (osx),
        .out_sy    (osy),
        .out_ex    (oex),
        .out_ey    (oey)
    );

    assign m_tdata = DW'({oey, oex, osy, osx});

endmodule

// File: src/lswc_ctrl.sv
// Sequencer of the clipper: accept, evaluate, multiply, serial divide, update, output.
// Depends on lswc_pkg.
module lswc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lswc_pkg::status_t st,
    output lswc_pkg::cmd_t  cmd
);
    import lswc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (st.trivial_acc || st.trivial_rej) state_next = ST_OUT;
                else if (st.zero_span)                state_next = ST_UPD;
                else                                  state_next = ST_MUL;
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (st.div_done) state_next = ST_UPD;
            end
            ST_UPD: state_next = ST_EVAL;
            ST_OUT: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EVAL: cmd.setup    = !(st.trivial_acc || st.trivial_rej);
            ST_MUL:  cmd.mul      = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_UPD:  cmd.update   = 1'b1;
            ST_OUT:  cmd.emit     = st.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// File: src/lswc_datapath.sv
// Datapath: endpoint registers, outcodes, multiplier, restoring divider,
// saturating update and the result register. Depends on lswc_pkg.
module lswc_datapath #(
    parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lswc_pkg::cmd_t                cmd,
    output lswc_pkg::status_t             st,
    input  logic signed [COORD_WIDTH-1:0] win_x_min,
    input  logic signed [COORD_WIDTH-1:0] win_x_max,
    input  logic signed [COORD_WIDTH-1:0] win_y_min,
    input  logic signed [COORD_WIDTH-1:0] win_y_max,
    input  logic signed [COORD_WIDTH-1:0] in_sx,
    input  logic signed [COORD_WIDTH-1:0] in_sy,
    input  logic signed [COORD_WIDTH-1:0] in_ex,
    input  logic signed [COORD_WIDTH-1:0] in_ey,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic                          out_acc,
    output logic [COORD_WIDTH-1:0]        out_sx,
    output logic [COORD_WIDTH-1:0]        out_sy,
    output logic [COORD_WIDTH-1:0]        out_ex,
    output logic [COORD_WIDTH-1:0]        out_ey
);
    import lswc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int CW = $clog2(PW);
    localparam logic [PW-1:0] QLIM = PW'(1) << (W + 1);
    localparam logic signed [W+2:0] CMAX = (W+3)'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [W+2:0] CMIN = -CMAX - (W+3)'(1);

    function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
                                           input logic signed [W-1:0] y,
                                           input logic signed [W-1:0] xmin,
                                           input logic signed [W-1:0] xmax,
                                           input logic signed [W-1:0] ymin,
                                           input logic signed [W-1:0] ymax);
        logic [3:0] c;
        c = '0;
        if (x < xmin)      c = c | OC_LEFT;
        else if (x > xmax) c = c | OC_RIGHT;
        if (y < ymin)      c = c | OC_BELOW;
        else if (y > ymax) c = c | OC_ABOVE;
        return c;
    endfunction

    function automatic logic [W:0] mag(input logic signed [W:0] v);
        return v[W] ? (W+1)'(0) - v : v;
    endfunction

    logic signed [W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [W:0]   w_reg, h_reg;
    logic [2:0]          moves_reg;
    logic                on_start_reg, axis_x_reg, neg_reg, zero_reg;
    logic signed [W-1:0] edge_reg, base_reg;
    logic [W:0]          num_mag_reg, dlt_mag_reg, den_mag_reg;
    logic [PW-1:0]       quo_reg;
    logic [W:0]          rem_reg;
    logic [CW-1:0]       cnt_reg;
    logic                m_valid_reg;
    logic                acc_reg;
    logic [W-1:0]        osx_reg, osy_reg, oex_reg, oey_reg;

    logic [3:0]          sc, ec, cur;
    logic                axis_x;
    logic signed [W-1:0] edge_v, base_v, from_v;
    logic signed [W:0]   num_v, den_v, dlt_v;
    logic [W+1:0]        trial;
    logic                ge;
    logic [W+1:0]        qc;
    logic signed [W+2:0] sum;
    logic signed [W-1:0] val;
    logic signed [W-1:0] nx, ny;

    assign sc = outcode(sx_reg, sy_reg, win_x_min, win_x_max, win_y_min, win_y_max);
    assign ec = outcode(ex_reg, ey_reg, win_x_min, win_x_max, win_y_min, win_y_max);

    assign st.trivial_acc = ((sc | ec) == 4'b0000);
    assign st.trivial_rej = ((sc & ec) != 4'b0000) || (moves_reg >= 3'(CLIP_LIMIT));
    assign st.zero_span   = (w_reg == '0) || (h_reg == '0);
    assign st.div_done    = (cnt_reg == CW'(PW - 1));
    assign st.out_free    = !m_valid_reg || m_tready;

    // move setup: outside point (start first), crossed edge, operands
    always_comb begin
        cur    = (sc != 4'b0000) ? sc : ec;
        axis_x = (cur < OC_BELOW);
        if (axis_x) begin
            edge_v = ((cur & OC_LEFT) != 4'b0000) ? win_x_min : win_x_max;
            base_v = sy_reg;
            from_v = sx_reg;
            num_v  = h_reg;
            den_v  = w_reg;
        end else begin
            edge_v = ((cur & OC_BELOW) != 4'b0000) ? win_y_min : win_y_max;
            base_v = sx_reg;
            from_v = sy_reg;
            num_v  = w_reg;
            den_v  = h_reg;
        end
        dlt_v = (W+1)'(edge_v) - (W+1)'(from_v);
    end

    // restoring divide step
    assign trial = {rem_reg, quo_reg[PW-1]};
    assign ge    = (trial >= {1'b0, den_mag_reg});

    // saturating update
    always_comb begin
        qc  = (quo_reg > QLIM) ? QLIM[W+1:0] : quo_reg[W+1:0];
        sum = (W+3)'(base_reg) + (neg_reg ? -$signed({1'b0, qc}) : $signed({1'b0, qc}));
        if (zero_reg)         val = base_reg;
        else if (sum > CMAX)  val = CMAX[W-1:0];
        else if (sum < CMIN)  val = CMIN[W-1:0];
        else                  val = sum[W-1:0];
        nx = axis_x_reg ? edge_reg : val;
        ny = axis_x_reg ? val : edge_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sx_reg    <= in_sx;
            sy_reg    <= in_sy;
            ex_reg    <= in_ex;
            ey_reg    <= in_ey;
            w_reg     <= (W+1)'(in_ex) - (W+1)'(in_sx);
            h_reg     <= (W+1)'(in_ey) - (W+1)'(in_sy);
            moves_reg <= '0;
        end
        if (cmd.setup) begin
            on_start_reg <= (sc != 4'b0000);
            axis_x_reg   <= axis_x;
            edge_reg     <= edge_v;
            base_reg     <= base_v;
            zero_reg     <= st.zero_span;
            neg_reg      <= num_v[W] ^ dlt_v[W] ^ den_v[W];
            num_mag_reg  <= mag(num_v);
            dlt_mag_reg  <= mag(dlt_v);
            den_mag_reg  <= mag(den_v);
        end
        if (cmd.mul) begin
            quo_reg <= num_mag_reg * dlt_mag_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            quo_reg <= {quo_reg[PW-2:0], ge};
            rem_reg <= ge ? (W+1)'(trial - {1'b0, den_mag_reg}) : trial[W:0];
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.update) begin
            moves_reg <= moves_reg + 3'd1;
            if (on_start_reg) begin
                sx_reg <= nx;
                sy_reg <= ny;
            end else begin
                ex_reg <= nx;
                ey_reg <= ny;
            end
        end
        if (cmd.emit) begin
            acc_reg <= st.trivial_acc;
            osx_reg <= sx_reg;
            osy_reg <= sy_reg;
            oex_reg <= ex_reg;
            oey_reg <= ey_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign out_acc  = acc_reg;
    assign out_sx   = osx_reg;
    assign out_sy   = osy_reg;
    assign out_ex   = oex_reg;
    assign out_ey   = oey_reg;

endmodule

// File: src/lswc_checker.sv
// Port-level checks for line_segment_window_clip_core, bound to the top.
// Depends on nothing beyond the top level's ports.
module lswc_checker #(
    parameter int COORD_WIDTH = 24
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               pready,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic                               m_tuser
);
    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // one segment at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second item while busy");

    // no result shows up in the cycle after an accept
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // reset leaves no result pending
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && pready)
        else $error("result pending after reset");

endmodule

bind line_segment_window_clip_core lswc_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lswc_checker (.*);

// File: tb/tb_line_segment_window_clip_core.sv
// Self-checking testbench for line_segment_window_clip_core: directed and random segments
// are checked against a bench clipper or typed results, over several window settings.
// Depends on lswc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_line_segment_window_clip_core;
    import lswc_pkg::*;

    localparam int W = COORD_WIDTH_DEF;
    localparam longint CMAX = (longint'(1) << (W - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint unsigned QLIM = longint'(1) << (W + 1);

    typedef logic signed [W-1:0] coord_t;

    typedef struct {
        coord_t sx, sy, ex, ey;
    } segment_t;

    typedef struct {
        bit     acc;
        coord_t sx, sy, ex, ey;
    } clipped_t;

    typedef struct {
        coord_t sx, sy, ex, ey;
        bit     typed;
        bit     acc;
    } seg_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;  // start_x, start_y, end_x, end_y
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;       // clip_start_x, clip_start_y, clip_end_x, clip_end_y
    logic        m_tuser;       // accepted

    longint   win_x_min, win_x_max, win_y_min, win_y_max;
    clipped_t clip_q[$];
    bit       failed = 1'b0;
    int       tx_idle = 0, rx_idle = 0;

    line_segment_window_clip_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [3:0] region_code(longint x, longint y);
        logic [3:0] c;
        c = 4'b0000;
        if (x < win_x_min) c |= OC_LEFT;
        else if (x > win_x_max) c |= OC_RIGHT;
        if (y < win_y_min) c |= OC_BELOW;
        else if (y > win_y_max) c |= OC_ABOVE;
        return c;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // base + num * delta / den, truncated toward zero, then saturated
    function automatic longint edge_point(longint base, longint num, longint delta, longint den);
        bit               neg;
        longint unsigned  q;
        longint           r;
        neg = ((num < 0) != (delta < 0)) != (den < 0);
        q = (magnitude(num) * magnitude(delta)) / magnitude(den);
        if (q > QLIM) q = QLIM;
        r = neg ? base - longint'(q) : base + longint'(q);
        if (r > CMAX) r = CMAX;
        if (r < CMIN) r = CMIN;
        return r;
    endfunction

    function automatic clipped_t clip_segment(segment_t s);
        longint     sx, sy, ex, ey, w, h, nx, ny;
        logic [3:0] sc, ec, cur;
        int         moves;
        bit         on_start;
        clipped_t   r;
        sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
        w = ex - sx; h = ey - sy;
        sc = region_code(sx, sy);
        ec = region_code(ex, ey);
        moves = 0;
        forever begin
            if ((sc | ec) == 0) begin
                r.acc = 1'b1;
                break;
            end
            if ((sc & ec) != 0 || moves >= CLIP_LIMIT) begin
                r.acc = 1'b0;
                break;
            end
            moves++;
            on_start = (sc != 0);
            cur = on_start ? sc : ec;
            if (cur < OC_BELOW) begin
                nx = (cur & OC_LEFT) ? win_x_min : win_x_max;
                ny = (h == 0 || w == 0) ? sy : edge_point(sy, h, nx - sx, w);
            end else begin
                ny = (cur & OC_BELOW) ? win_y_min : win_y_max;
                nx = (w == 0 || h == 0) ? sx : edge_point(sx, w, ny - sy, h);
            end
            if (on_start) begin
                sx = nx; sy = ny; sc = region_code(sx, sy);
            end else begin
                ex = nx; ey = ny; ec = region_code(ex, ey);
            end
        end
        r.sx = coord_t'(sx); r.sy = coord_t'(sy);
        r.ex = coord_t'(ex); r.ey = coord_t'(ey);
        return r;
    endfunction

    task automatic write_window(logic [1:0] idx, longint value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_X_MIN: win_x_min = coord_t'(value);
            REG_X_MAX: win_x_max = coord_t'(value);
            REG_Y_MIN: win_y_min = coord_t'(value);
            REG_Y_MAX: win_y_max = coord_t'(value);
            default:   ;
        endcase
    endtask

    task automatic set_window(longint x0, longint x1, longint y0, longint y1);
        s_tvalid <= 1'b0;
        while (clip_q.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        write_window(REG_X_MIN, x0);
        write_window(REG_X_MAX, x1);
        write_window(REG_Y_MIN, y0);
        write_window(REG_Y_MAX, y1);
    endtask

    // leaves s_tvalid high after the item is taken; the next call or the caller drops it
    task automatic send_segment(segment_t s, bit typed, clipped_t typed_res);
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {s.ey, s.ex, s.sy, s.sx};
        do @(posedge aclk); while (!s_tready);
        clip_q.push_back(typed ? typed_res : clip_segment(s));
    endtask

    function automatic coord_t rand_coord(int spread);
        case ($urandom_range(9))
            0: return coord_t'($urandom);
            1: return $urandom_range(1) ? coord_t'(CMAX) : coord_t'(CMIN);
            default: return coord_t'(int'($urandom_range(2 * spread)) - spread);
        endcase
    endfunction

    task automatic random_segments(int n, int spread);
        segment_t s;
        clipped_t none;
        none = '{default: 0};
        repeat (n) begin
            s.sx = rand_coord(spread); s.sy = rand_coord(spread);
            s.ex = rand_coord(spread); s.ey = rand_coord(spread);
            send_segment(s, 1'b0, none);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge aclk) begin
        clipped_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (clip_q.size() == 0) begin
                $error("result item with no expectation pending");
                failed = 1'b1;
            end else begin
                e = clip_q.pop_front();
                if (m_tuser !== e.acc) begin
                    $error("accepted: expected %0d actual %0d", e.acc, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata[23:0] !== e.sx) begin
                    $error("clip_start_x: expected %0d actual %0d", e.sx, $signed(m_tdata[23:0]));
                    failed = 1'b1;
                end
                if (m_tdata[47:24] !== e.sy) begin
                    $error("clip_start_y: expected %0d actual %0d", e.sy, $signed(m_tdata[47:24]));
                    failed = 1'b1;
                end
                if (m_tdata[71:48] !== e.ex) begin
                    $error("clip_end_x: expected %0d actual %0d", e.ex, $signed(m_tdata[71:48]));
                    failed = 1'b1;
                end
                if (m_tdata[95:72] !== e.ey) begin
                    $error("clip_end_y: expected %0d actual %0d", e.ey, $signed(m_tdata[95:72]));
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        seg_row_t rows[] = '{
            // inside: passed through unchanged
            '{0, 0, 256, 256, 1, 1},
            '{-81920, -61440, 81920, 61440, 1, 1},
            // both left, both below, both at the extremes: rejected untouched
            '{-100000, 0, -90000, 10, 1, 0},
            '{0, -70000, 5000, -90000, 1, 0},
            '{-8388608, -8388608, -8388608, -8388608, 1, 0},
            '{8388607, 8388607, 8388607, 8388607, 1, 0},
            '{8388607, -8388608, 8388607, 8388607, 1, 0},
            // crossings, zero spans, corners, rejection after a move
            '{-100000, 0, 100000, 0, 0, 0},
            '{0, -70000, 0, 70000, 0, 0},
            '{-8388608, -8388608, 8388607, 8388607, 0, 0},
            '{-8388608, 8388607, 8388607, -8388608, 0, 0},
            '{0, 0, 100000, 50000, 0, 0},
            '{0, 0, 1000, 100000, 0, 0},
            '{-100000, 50000, 0, 100000, 0, 0},
            '{-90000, 60000, -70000, 70000, 0, 0},
            '{100000, -70000, -100000, 70000, 0, 0},
            '{-81921, 0, 81921, 1, 0, 0},
            '{0, 61441, 1, -61441, 0, 0},
            '{-8388608, 0, 8388607, 0, 0, 0}
        };
        segment_t s;
        clipped_t t;
        win_x_min = -81920; win_x_max = 81920;
        win_y_min = -61440; win_y_max = 61440;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle = 35; rx_idle = 71;
        foreach (rows[i]) begin
            s = '{rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey};
            t = '{rows[i].acc, rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey};
            send_segment(s, rows[i].typed, t);
        end
        random_segments(550, 200000);

        tx_idle = 71; rx_idle = 35;
        set_window(-5000, 30000, -100, 20000);
        random_segments(450, 60000);
        set_window(CMIN, CMAX, CMIN, CMAX);
        random_segments(100, 200000);
        // inverted window: the move limit has to end the loop
        set_window(10000, -10000, 8000, -8000);
        random_segments(150, 40000);

        tx_idle = 0; rx_idle = 0;
        set_window(CMAX, CMAX, CMIN, CMIN);
        random_segments(100, 200000);
        set_window(-300, 700, -512, 256);
        random_segments(450, 3000);

        s_tvalid <= 1'b0;
        while (clip_q.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
